// ----- src/adaptive_two_way_traffic_light_defines.svh -----
// Assertion macros for the two-way traffic light.
// Used by the top level; expects clk and arst_n in scope.
`ifndef ADAPTIVE_TWO_WAY_TRAFFIC_LIGHT_DEFINES_SVH
`define ADAPTIVE_TWO_WAY_TRAFFIC_LIGHT_DEFINES_SVH

// same-cycle implication, off during reset
`define ATL_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("traffic light check failed");

// next-cycle implication, off during reset
`define ATL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("traffic light check failed");

`endif

// ----- src/atl_pkg.sv -----
// Types, constants and per-tick helper functions for the traffic light.
// No dependencies.
`default_nettype none

package atl_pkg;

	localparam int RATIO_FRAC_BITS = 7;
	localparam int RATIO_W         = 9;
	localparam int SPAN_W          = 7;
	localparam int CNT_W           = 8;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 8;

	typedef logic signed [RATIO_W-1:0] ratio_t;
	typedef logic [SPAN_W-1:0]         span_t;
	typedef logic [CNT_W-1:0]          cnt_t;
	typedef logic [1:0]                light_t;
	typedef logic [1:0]                phase_t;
	typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0]     cfg_data_t;

	localparam ratio_t RATIO_ONE = ratio_t'(1 << RATIO_FRAC_BITS);

	localparam phase_t PH_GREEN   = 2'd0;
	localparam phase_t PH_YELLOW  = 2'd1;
	localparam phase_t PH_ALL_RED = 2'd2;

	localparam light_t LIGHT_RED    = 2'd0;
	localparam light_t LIGHT_YELLOW = 2'd1;
	localparam light_t LIGHT_GREEN  = 2'd2;

	localparam cfg_idx_t REG_GREEN_SPAN  = 2'd0;
	localparam cfg_idx_t REG_YELLOW      = 2'd1;
	localparam cfg_idx_t REG_ALL_RED     = 2'd2;
	localparam cfg_idx_t REG_EMPTY_TOL   = 2'd3;

	localparam span_t RST_GREEN_SPAN = 7'd60;
	localparam cnt_t  RST_YELLOW     = 8'd6;
	localparam cnt_t  RST_ALL_RED    = 8'd2;
	localparam cnt_t  RST_EMPTY_TOL  = 8'd6;

	localparam cnt_t UNTIMED   = 8'd255;
	localparam cnt_t MAX_GREEN = 8'd254;

	function automatic ratio_t clamp_ratio(input ratio_t raw);
		ratio_t r;
		r = raw;
		if (raw > RATIO_ONE)
			r = RATIO_ONE;
		else if (raw < -RATIO_ONE)
			r = -RATIO_ONE;
		return r;
	endfunction

	// floor(span * (ONE +/- r) / ONE), saturated below the untimed code
	function automatic cnt_t green_target(input span_t span, input logic lane,
			input ratio_t r);
		logic signed [RATIO_W:0]      w;
		logic [RATIO_W-1:0]           v;
		logic [SPAN_W+RATIO_W-1:0]    prod;
		logic [SPAN_W+RATIO_W-1:0]    t;
		w = lane ? ({RATIO_ONE[RATIO_W-1], RATIO_ONE} - {r[RATIO_W-1], r})
		         : ({RATIO_ONE[RATIO_W-1], RATIO_ONE} + {r[RATIO_W-1], r});
		v = w[RATIO_W-1:0];
		prod = {{RATIO_W{1'b0}}, span} * {{SPAN_W{1'b0}}, v};
		t = prod >> RATIO_FRAC_BITS;
		if (t > {{(SPAN_W+RATIO_W-CNT_W){1'b0}}, MAX_GREEN})
			return MAX_GREEN;
		return t[CNT_W-1:0];
	endfunction

	// other lane empty when the ratio sits within tol of the active lane's extreme
	function automatic logic other_lane_empty(input logic lane, input ratio_t r,
			input cnt_t tol);
		logic signed [RATIO_W:0] d;
		logic [RATIO_W:0]        mag;
		d = lane ? ({r[RATIO_W-1], r} + {RATIO_ONE[RATIO_W-1], RATIO_ONE})
		         : ({r[RATIO_W-1], r} - {RATIO_ONE[RATIO_W-1], RATIO_ONE});
		mag = (d < 0) ? $unsigned(-d) : $unsigned(d);
		return mag < {{(RATIO_W+1-CNT_W){1'b0}}, tol};
	endfunction

endpackage

`default_nettype wire

// ----- src/atl_ifs.sv -----
// Valid/ready channel interfaces: tick input, light result, config write.
// Depends on atl_pkg.
`default_nettype none

interface atl_tick_if;
	import atl_pkg::*;
	logic   valid;
	logic   ready;
	ratio_t car_ratio;
	modport source (output valid, output car_ratio, input ready);
	modport sink (input valid, input car_ratio, output ready);
endinterface

interface atl_light_if;
	import atl_pkg::*;
	logic   valid;
	logic   ready;
	light_t lane0_light;
	light_t lane1_light;
	logic   active_lane;
	cnt_t   time_left;
	modport source (output valid, output lane0_light, output lane1_light,
		output active_lane, output time_left, input ready);
	modport sink (input valid, input lane0_light, input lane1_light,
		input active_lane, input time_left, output ready);
endinterface

interface atl_cfg_if;
	import atl_pkg::*;
	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/adaptive_two_way_traffic_light.sv -----
// Two-way adaptive traffic light: every accepted tick beat yields one result
// beat in the next cycle, carrying both lights, the active lane and the ticks
// left in the phase. A tick is taken every cycle while the result register is
// empty or being drained, so a sustained rate of one tick per cycle holds
// whenever the result side keeps ready high; the only limit is the single
// result register. Config writes are always accepted (ready always high).
// Depends on atl_pkg, atl_ifs and adaptive_two_way_traffic_light_defines.svh.
`default_nettype none

module adaptive_two_way_traffic_light (
	input  wire           clk,
	input  wire           arst_n,
	atl_tick_if.sink      tick,
	atl_light_if.source   lights,
	atl_cfg_if.sink       cfg
);
	import atl_pkg::*;
	`include "adaptive_two_way_traffic_light_defines.svh"

	span_t  green_span_q;
	cnt_t   yellow_q;
	cnt_t   all_red_q;
	cnt_t   empty_tol_q;

	phase_t phase_q;
	logic   green_lane_q;
	cnt_t   phase_count_q;

	logic   out_valid_q;
	light_t lane0_q;
	light_t lane1_q;
	logic   active_q;
	cnt_t   time_left_q;

	logic   tick_acc;
	ratio_t r;
	cnt_t   target;
	cnt_t   cnt_dec;
	phase_t phase_d;
	logic   lane_d;
	cnt_t   count_d;
	light_t l0_d;
	light_t l1_d;

	assign cfg.ready  = 1'b1;
	assign tick.ready = !out_valid_q || lights.ready;
	assign tick_acc   = tick.valid && tick.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			green_span_q <= RST_GREEN_SPAN;
			yellow_q     <= RST_YELLOW;
			all_red_q    <= RST_ALL_RED;
			empty_tol_q  <= RST_EMPTY_TOL;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_GREEN_SPAN: green_span_q <= cfg.data[SPAN_W-1:0];
				REG_YELLOW:     yellow_q     <= cfg.data;
				REG_ALL_RED:    all_red_q    <= cfg.data;
				REG_EMPTY_TOL:  empty_tol_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// per-tick phase update
	always_comb begin
		r       = clamp_ratio(tick.car_ratio);
		phase_d = phase_q;
		lane_d  = green_lane_q;
		count_d = phase_count_q;
		cnt_dec = (phase_count_q != '0) ? phase_count_q - 1'b1 : '0;
		target  = green_target(green_span_q, green_lane_q, r);
		case (phase_q)
			PH_YELLOW, PH_ALL_RED: begin
				count_d = cnt_dec;
				if (cnt_dec == '0) begin
					if (phase_q == PH_YELLOW) begin
						phase_d = PH_ALL_RED;
						count_d = all_red_q;
					end else begin
						phase_d = PH_GREEN;
						count_d = target;
					end
				end
			end
			default: begin
				phase_d = PH_GREEN;
				if (phase_count_q == UNTIMED)
					count_d = target;
				else
					count_d = (cnt_dec < target) ? cnt_dec : target;
				if (count_d == '0) begin
					if (other_lane_empty(green_lane_q, r, empty_tol_q)) begin
						count_d = target;
					end else begin
						lane_d  = !green_lane_q;
						phase_d = PH_YELLOW;
						count_d = yellow_q;
					end
				end
			end
		endcase

		l0_d = LIGHT_RED;
		l1_d = LIGHT_RED;
		if (phase_d == PH_YELLOW) begin
			// lane_d already names the incoming lane
			if (lane_d) l0_d = LIGHT_YELLOW;
			else        l1_d = LIGHT_YELLOW;
		end else if (phase_d == PH_GREEN) begin
			if (lane_d) l1_d = LIGHT_GREEN;
			else        l0_d = LIGHT_GREEN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_GREEN;
			green_lane_q  <= 1'b0;
			phase_count_q <= UNTIMED;
			out_valid_q   <= 1'b0;
		end else begin
			if (tick_acc) begin
				phase_q       <= phase_d;
				green_lane_q  <= lane_d;
				phase_count_q <= count_d;
				out_valid_q   <= 1'b1;
			end else if (lights.ready) begin
				out_valid_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			lane0_q     <= l0_d;
			lane1_q     <= l1_d;
			active_q    <= lane_d;
			time_left_q <= count_d;
		end
	end

	assign lights.valid       = out_valid_q;
	assign lights.lane0_light = lane0_q;
	assign lights.lane1_light = lane1_q;
	assign lights.active_lane = active_q;
	assign lights.time_left   = time_left_q;

	`ATL_ASSERT_NEXT(a_tick_gives_result, tick_acc, out_valid_q && active_q == green_lane_q)
	`ATL_ASSERT_NEXT(a_lane_swap_at_yellow, tick_acc && lane_d != green_lane_q, phase_q == PH_YELLOW)
	`ATL_ASSERT_SAME(a_all_red_shown, out_valid_q && phase_q == PH_ALL_RED,
		lane0_q == LIGHT_RED && lane1_q == LIGHT_RED)
	`ATL_ASSERT_SAME(a_single_green, out_valid_q,
		!(lane0_q == LIGHT_GREEN && lane1_q == LIGHT_GREEN))

endmodule

`default_nettype wire
